[sv/baf_pkg.sv]
// Shared types and constants for the beam axis frame builder.
// No dependencies; every other file of the block refers to this package.
package baf_pkg;

    localparam int COORD_W  = 32;           // Q16.16 coordinate
    localparam int DIFF_W   = COORD_W + 1;  // exact end - start
    localparam int WIDE_W   = 35;           // vector component fed to a normalizer
    localparam int Q_W      = 16;           // Q2.14 axis component
    localparam int SCL_W    = 30;           // scaled magnitude, largest in [2^29, 2^30)
    localparam int SQ_W     = 2 * SCL_W;
    localparam int SUM_W    = 64;
    localparam int BL_W     = 6;
    localparam int ISQ_STEPS = 32;          // one root bit per stage
    localparam int LEN_W    = 32;
    localparam int DEN_W    = LEN_W + 1;
    localparam int QUO_W    = 15;           // quotient never exceeds 16384
    localparam int REM_W    = 48;
    localparam int PROD_W   = 32;
    localparam int MINLEN_W = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic signed [Q_W-1:0] ONE_Q14 = 16'sd16384;

    // Normalizer latency: magnitude, bit length, scale, square, sum,
    // root steps, divider setup, quotient steps.
    localparam int NORM_LAT = 5 + ISQ_STEPS + 1 + QUO_W;

    // Word index of the configuration register.
    localparam logic [APB_ADDR_W-3:0] REG_MIN_LENGTH = '0;

    typedef logic signed [Q_W-1:0]    q14_t;
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef q14_t  [2:0] qvec_t;
    typedef wide_t [2:0] wvec_t;

    typedef enum logic [2:0] {
        CASE_ON_X,
        CASE_ON_Y,
        CASE_ON_Z,
        CASE_ZERO_Z,
        CASE_ZERO_Y,
        CASE_ZERO_X,
        CASE_GENERAL
    } axis_case_t;

    typedef struct packed {
        logic       too_short;
        axis_case_t kind;
    } meta_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_z;
    } in_t;

    typedef struct packed {
        q14_t axis_x_x;
        q14_t axis_x_y;
        q14_t axis_x_z;
        q14_t axis_y_x;
        q14_t axis_y_y;
        q14_t axis_y_z;
        q14_t axis_z_x;
        q14_t axis_z_y;
        q14_t axis_z_z;
        logic too_short;
    } out_t;

    typedef struct packed {
        logic [SUM_W-1:0]          n;
        logic [SUM_W-1:0]          res;
        logic [2:0][SCL_W-1:0]     mg;
        logic [2:0]                sgn;
    } isq_stage_t;

    typedef struct packed {
        logic [2:0][REM_W-1:0]     rem;
        logic [2:0][QUO_W-1:0]     quo;
        logic [DEN_W-1:0]          den;
        logic [2:0]                sgn;
    } div_stage_t;

endpackage

[sv/baf_norm.sv]
// Pipelined vector normalizer: scale, sum of squares, bit-per-stage root,
// bit-per-stage quotient. Depends on baf_pkg.
module baf_norm (
    input  logic           clk,
    input  logic           en,
    input  baf_pkg::wvec_t vin,
    output baf_pkg::qvec_t vout
);

    logic [2:0][baf_pkg::WIDE_W-1:0] mag_reg;
    logic [2:0]                      sgn_reg;
    logic [2:0][baf_pkg::WIDE_W-1:0] magb_reg;
    logic [2:0]                      sgnb_reg;
    logic [baf_pkg::BL_W-1:0]        bl_reg;
    logic [baf_pkg::BL_W-1:0]        bl_next;
    logic [baf_pkg::WIDE_W-1:0]      mag_or;
    logic [2:0][baf_pkg::WIDE_W-1:0] sh;
    logic [2:0][baf_pkg::SCL_W-1:0]  mgc_reg;
    logic [2:0]                      sgnc_reg;
    logic [2:0][baf_pkg::SQ_W-1:0]   sqd_reg;
    logic [2:0][baf_pkg::SCL_W-1:0]  mgd_reg;
    logic [2:0]                      sgnd_reg;

    baf_pkg::isq_stage_t isq_reg [0:baf_pkg::ISQ_STEPS];
    baf_pkg::div_stage_t div_reg [0:baf_pkg::QUO_W];

    // Magnitudes and signs
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sgn_reg[i] <= vin[i][baf_pkg::WIDE_W-1];
                mag_reg[i] <= vin[i][baf_pkg::WIDE_W-1] ? baf_pkg::WIDE_W'(-vin[i])
                                                        : baf_pkg::WIDE_W'(vin[i]);
            end
        end
    end

    // Bit length of the largest magnitude equals that of the OR of all three
    always_comb
    begin
        mag_or  = mag_reg[0] | mag_reg[1] | mag_reg[2];
        bl_next = '0;
        for (int i = 0; i < baf_pkg::WIDE_W; i++)
        begin
            if (mag_or[i])
            begin
                bl_next = baf_pkg::BL_W'(i + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bl_reg   <= bl_next;
            magb_reg <= mag_reg;
            sgnb_reg <= sgn_reg;
        end
    end

    // Scale so the largest magnitude sits in [2^29, 2^30)
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (bl_reg > baf_pkg::BL_W'(baf_pkg::SCL_W))
            begin
                sh[i] = magb_reg[i] >> (bl_reg - baf_pkg::BL_W'(baf_pkg::SCL_W));
            end
            else
            begin
                sh[i] = magb_reg[i] << (baf_pkg::BL_W'(baf_pkg::SCL_W) - bl_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mgc_reg[i] <= sh[i][baf_pkg::SCL_W-1:0];
            end
            sgnc_reg <= sgnb_reg;
        end
    end

    // Squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sqd_reg[i] <= {{baf_pkg::SCL_W{1'b0}}, mgc_reg[i]}
                            * {{baf_pkg::SCL_W{1'b0}}, mgc_reg[i]};
            end
            mgd_reg  <= mgc_reg;
            sgnd_reg <= sgnc_reg;
        end
    end

    // Sum of squares opens the root pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            isq_reg[0].n   <= baf_pkg::SUM_W'(sqd_reg[0]) + baf_pkg::SUM_W'(sqd_reg[1])
                            + baf_pkg::SUM_W'(sqd_reg[2]);
            isq_reg[0].res <= '0;
            isq_reg[0].mg  <= mgd_reg;
            isq_reg[0].sgn <= sgnd_reg;
        end
    end

    // One root bit per stage
    for (genvar k = 0; k < baf_pkg::ISQ_STEPS; k++)
    begin : g_isq
        localparam logic [baf_pkg::SUM_W-1:0] BIT_K =
            baf_pkg::SUM_W'(1) << (2 * (baf_pkg::ISQ_STEPS - 1 - k));
        logic [baf_pkg::SUM_W-1:0] trial;
        baf_pkg::isq_stage_t       nxt;

        always_comb
        begin
            trial = isq_reg[k].res + BIT_K;
            nxt   = isq_reg[k];
            if (isq_reg[k].n >= trial)
            begin
                nxt.n   = isq_reg[k].n - trial;
                nxt.res = (isq_reg[k].res >> 1) + BIT_K;
            end
            else
            begin
                nxt.res = isq_reg[k].res >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                isq_reg[k+1] <= nxt;
            end
        end
    end

    // Divider setup: (mg*32768 + len) / (2*len)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                div_reg[0].rem[i] <=
                    baf_pkg::REM_W'({isq_reg[baf_pkg::ISQ_STEPS].mg[i], 15'b0})
                    + baf_pkg::REM_W'(isq_reg[baf_pkg::ISQ_STEPS].res[baf_pkg::LEN_W-1:0]);
            end
            div_reg[0].quo <= '0;
            div_reg[0].den <= {isq_reg[baf_pkg::ISQ_STEPS].res[baf_pkg::LEN_W-1:0], 1'b0};
            div_reg[0].sgn <= isq_reg[baf_pkg::ISQ_STEPS].sgn;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar j = 0; j < baf_pkg::QUO_W; j++)
    begin : g_div
        localparam int B = baf_pkg::QUO_W - 1 - j;
        logic [baf_pkg::REM_W-1:0] dsh;
        baf_pkg::div_stage_t       nxt;

        always_comb
        begin
            dsh = baf_pkg::REM_W'(div_reg[j].den) << B;
            nxt = div_reg[j];
            for (int i = 0; i < 3; i++)
            begin
                if (div_reg[j].rem[i] >= dsh)
                begin
                    nxt.rem[i]    = div_reg[j].rem[i] - dsh;
                    nxt.quo[i][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[j+1] <= nxt;
            end
        end
    end

    // Clamp and apply signs
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (baf_pkg::Q_W'(div_reg[baf_pkg::QUO_W].quo[i]) > baf_pkg::ONE_Q14)
            begin
                vout[i] = div_reg[baf_pkg::QUO_W].sgn[i] ? -baf_pkg::ONE_Q14
                                                         : baf_pkg::ONE_Q14;
            end
            else if (div_reg[baf_pkg::QUO_W].sgn[i])
            begin
                vout[i] = -baf_pkg::Q_W'(div_reg[baf_pkg::QUO_W].quo[i]);
            end
            else
            begin
                vout[i] = baf_pkg::Q_W'(div_reg[baf_pkg::QUO_W].quo[i]);
            end
        end
    end

endmodule

[sv/baf_cross.sv]
// Two-stage Q2.14 cross product with rounding and clamping.
// Depends on baf_pkg.
module baf_cross (
    input  logic           clk,
    input  logic           en,
    input  baf_pkg::qvec_t ax,
    input  baf_pkg::qvec_t ay,
    output baf_pkg::qvec_t az
);

    logic signed [5:0][baf_pkg::PROD_W-1:0] prod_reg;
    logic signed [2:0][baf_pkg::PROD_W-1:0] diff;
    logic signed [2:0][baf_pkg::PROD_W-1:0] rnd;
    baf_pkg::qvec_t                         az_next;
    baf_pkg::qvec_t                         az_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= baf_pkg::PROD_W'($signed(ax[1])) * baf_pkg::PROD_W'($signed(ay[2]));
            prod_reg[1] <= baf_pkg::PROD_W'($signed(ax[2])) * baf_pkg::PROD_W'($signed(ay[1]));
            prod_reg[2] <= baf_pkg::PROD_W'($signed(ax[2])) * baf_pkg::PROD_W'($signed(ay[0]));
            prod_reg[3] <= baf_pkg::PROD_W'($signed(ax[0])) * baf_pkg::PROD_W'($signed(ay[2]));
            prod_reg[4] <= baf_pkg::PROD_W'($signed(ax[0])) * baf_pkg::PROD_W'($signed(ay[1]));
            prod_reg[5] <= baf_pkg::PROD_W'($signed(ax[1])) * baf_pkg::PROD_W'($signed(ay[0]));
        end
    end

    // Round half up to Q2.14 (floor after adding half), clamp to one
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = $signed(prod_reg[2*i]) - $signed(prod_reg[2*i+1]);
            rnd[i]  = ($signed(diff[i]) + 32'sd8192) >>> 14;
            if ($signed(rnd[i]) > 32'sd16384)
            begin
                az_next[i] = baf_pkg::ONE_Q14;
            end
            else if ($signed(rnd[i]) < -32'sd16384)
            begin
                az_next[i] = -baf_pkg::ONE_Q14;
            end
            else
            begin
                az_next[i] = rnd[i][baf_pkg::Q_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            az_reg <= az_next;
        end
    end

    assign az = az_reg;

endmodule

[sv/beam_axis_frame_builder.sv]
// Top level of the beam axis frame builder: input stages, normalizers,
// cross product, output register and APB register. Depends on baf_pkg,
// baf_norm and baf_cross.
//
// Each request carries a beam's two end points (signed Q16.16) and yields one
// 3x3 frame in Q2.14 plus a too_short flag. The block is a single pipeline
// that takes one request per clock while it is not held, and passes it through
// three input stages, a 53-stage normalizer set by its bit-per-stage square
// root and divider, frame selection, two cross-product stages that run beside
// the two delay stages after selection, and the output register. The whole
// pipeline moves together: it holds while a result sits
// in the output register and out_stall is high, and in_stall then stays high.
// min_length is the only register, at byte address 0, reset value 1; write it
// only while the pipeline is empty.
module beam_axis_frame_builder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  baf_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output baf_pkg::out_t                  out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [baf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [baf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [baf_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic                              en;
    logic [baf_pkg::MINLEN_W-1:0]      min_length_reg;

    // Stage 1: difference
    logic signed [2:0][baf_pkg::DIFF_W-1:0] s1_d_reg;
    logic                                   s1_vld_reg;

    // Stage 2: squares, case, normalizer operands
    logic [2:0]                             nz;
    logic [2:0][baf_pkg::DIFF_W-1:0]        mag;
    logic signed [baf_pkg::WIDE_W-1:0]      dsum;
    logic [2:0][2*baf_pkg::MINLEN_W-1:0]    s2_sq_reg;
    logic [2*baf_pkg::MINLEN_W-1:0]         s2_minsq_reg;
    logic                                   s2_small_reg;
    logic                                   s2_zero_reg;
    baf_pkg::axis_case_t                    kind_next;
    baf_pkg::axis_case_t                    s2_kind_reg;
    baf_pkg::wvec_t                         s2_vx_reg;
    baf_pkg::wvec_t                         s2_vy_reg;
    logic                                   s2_vld_reg;

    // Stage 3: length test
    logic [2*baf_pkg::MINLEN_W+1:0]         sqsum;
    baf_pkg::meta_t                         s3_meta_reg;
    baf_pkg::wvec_t                         s3_vx_reg;
    baf_pkg::wvec_t                         s3_vy_reg;
    logic                                   s3_vld_reg;

    // Side line alongside the normalizers
    baf_pkg::meta_t                         dl_meta_reg [0:baf_pkg::NORM_LAT-1];
    logic [baf_pkg::NORM_LAT-1:0]           dl_vld_reg;
    baf_pkg::qvec_t                         nx_out;
    baf_pkg::qvec_t                         ny_out;

    // Frame selection and cross product
    baf_pkg::qvec_t                         ay_next;
    baf_pkg::qvec_t                         p0_ax_reg, p0_ay_reg;
    baf_pkg::qvec_t                         p1_ax_reg, p1_ay_reg;
    baf_pkg::qvec_t                         p2_ax_reg, p2_ay_reg;
    baf_pkg::meta_t                         p0_meta_reg, p1_meta_reg, p2_meta_reg;
    logic                                   p0_vld_reg, p1_vld_reg, p2_vld_reg;
    baf_pkg::qvec_t                         cross_az;
    baf_pkg::qvec_t                         az_sel;

    baf_pkg::out_t                          out_next;
    baf_pkg::out_t                          out_reg;
    logic                                   out_vld_reg;

    // Advance everything unless a result is held at the output
    assign en       = !out_vld_reg || !out_stall;
    assign in_stall = !en;

    // ---------------- configuration ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= baf_pkg::MINLEN_W'(1);
        end
        else if (psel && penable && pwrite
                 && paddr[baf_pkg::APB_ADDR_W-1:2] == baf_pkg::REG_MIN_LENGTH)
        begin
            min_length_reg <= pwdata[baf_pkg::MINLEN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[baf_pkg::APB_ADDR_W-1:2] == baf_pkg::REG_MIN_LENGTH)
        begin
            prdata = baf_pkg::APB_DATA_W'(min_length_reg);
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            dl_vld_reg  <= '0;
            p0_vld_reg  <= 1'b0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= in_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            dl_vld_reg  <= {dl_vld_reg[baf_pkg::NORM_LAT-2:0], s3_vld_reg};
            p0_vld_reg  <= dl_vld_reg[baf_pkg::NORM_LAT-1];
            p1_vld_reg  <= p0_vld_reg;
            p2_vld_reg  <= p1_vld_reg;
            out_vld_reg <= p2_vld_reg;
        end
    end

    // ---------------- stage 1: exact difference ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_d_reg[0] <= baf_pkg::DIFF_W'(in_data.end_x) - baf_pkg::DIFF_W'(in_data.start_x);
            s1_d_reg[1] <= baf_pkg::DIFF_W'(in_data.end_y) - baf_pkg::DIFF_W'(in_data.start_y);
            s1_d_reg[2] <= baf_pkg::DIFF_W'(in_data.end_z) - baf_pkg::DIFF_W'(in_data.start_z);
        end
    end

    // ---------------- stage 2 ----------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nz[i]  = s1_d_reg[i] != '0;
            mag[i] = s1_d_reg[i][baf_pkg::DIFF_W-1] ? baf_pkg::DIFF_W'(-s1_d_reg[i])
                                                    : baf_pkg::DIFF_W'(s1_d_reg[i]);
        end
        dsum = baf_pkg::WIDE_W'($signed(s1_d_reg[0])) + baf_pkg::WIDE_W'($signed(s1_d_reg[1]));
        unique case (nz)
            3'b001:  kind_next = baf_pkg::CASE_ON_X;
            3'b010:  kind_next = baf_pkg::CASE_ON_Y;
            3'b100:  kind_next = baf_pkg::CASE_ON_Z;
            3'b011:  kind_next = baf_pkg::CASE_ZERO_Z;
            3'b101:  kind_next = baf_pkg::CASE_ZERO_Y;
            3'b110:  kind_next = baf_pkg::CASE_ZERO_X;
            default: kind_next = baf_pkg::CASE_GENERAL;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s2_sq_reg[i] <= mag[i][baf_pkg::MINLEN_W-1:0] * mag[i][baf_pkg::MINLEN_W-1:0];
                s2_vx_reg[i] <= baf_pkg::WIDE_W'($signed(s1_d_reg[i]));
            end
            s2_minsq_reg <= min_length_reg * min_length_reg;
            s2_small_reg <= (mag[0][baf_pkg::DIFF_W-1:baf_pkg::MINLEN_W] == '0)
                         && (mag[1][baf_pkg::DIFF_W-1:baf_pkg::MINLEN_W] == '0)
                         && (mag[2][baf_pkg::DIFF_W-1:baf_pkg::MINLEN_W] == '0);
            s2_zero_reg  <= nz == 3'b000;
            s2_kind_reg  <= kind_next;
            // General-case Y direction: (|dz|, |dz|, -sign(dz)*(dx+dy))
            s2_vy_reg[0] <= baf_pkg::WIDE_W'(mag[2]);
            s2_vy_reg[1] <= baf_pkg::WIDE_W'(mag[2]);
            s2_vy_reg[2] <= s1_d_reg[2][baf_pkg::DIFF_W-1] ? dsum : -dsum;
        end
    end

    // ---------------- stage 3: length test ----------------
    assign sqsum = (2*baf_pkg::MINLEN_W+2)'(s2_sq_reg[0])
                 + (2*baf_pkg::MINLEN_W+2)'(s2_sq_reg[1])
                 + (2*baf_pkg::MINLEN_W+2)'(s2_sq_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_meta_reg.too_short <= s2_zero_reg
                || (s2_small_reg && sqsum < (2*baf_pkg::MINLEN_W+2)'(s2_minsq_reg));
            s3_meta_reg.kind      <= s2_kind_reg;
            s3_vx_reg             <= s2_vx_reg;
            s3_vy_reg             <= s2_vy_reg;
        end
    end

    // ---------------- normalizers ----------------
    baf_norm u_norm_x (
        .clk  (clk),
        .en   (en),
        .vin  (s3_vx_reg),
        .vout (nx_out)
    );

    baf_norm u_norm_y (
        .clk  (clk),
        .en   (en),
        .vin  (s3_vy_reg),
        .vout (ny_out)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_meta_reg[0] <= s3_meta_reg;
            for (int k = 1; k < baf_pkg::NORM_LAT; k++)
            begin
                dl_meta_reg[k] <= dl_meta_reg[k-1];
            end
        end
    end

    // ---------------- Y axis selection ----------------
    always_comb
    begin
        ay_next = '0;
        unique case (dl_meta_reg[baf_pkg::NORM_LAT-1].kind)
            baf_pkg::CASE_ON_X, baf_pkg::CASE_ON_Z:
            begin
                ay_next[1] = baf_pkg::ONE_Q14;
            end
            baf_pkg::CASE_ON_Y:
            begin
                ay_next[2] = baf_pkg::ONE_Q14;
            end
            baf_pkg::CASE_ZERO_Z:
            begin
                ay_next[0] = -nx_out[1];
                ay_next[1] = nx_out[0];
            end
            baf_pkg::CASE_ZERO_Y:
            begin
                ay_next[0] = -nx_out[2];
                ay_next[2] = nx_out[0];
            end
            baf_pkg::CASE_ZERO_X:
            begin
                ay_next[1] = -nx_out[2];
                ay_next[2] = nx_out[1];
            end
            default:
            begin
                ay_next = ny_out;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_ax_reg   <= nx_out;
            p0_ay_reg   <= ay_next;
            p0_meta_reg <= dl_meta_reg[baf_pkg::NORM_LAT-1];
            p1_ax_reg   <= p0_ax_reg;
            p1_ay_reg   <= p0_ay_reg;
            p1_meta_reg <= p0_meta_reg;
            p2_ax_reg   <= p1_ax_reg;
            p2_ay_reg   <= p1_ay_reg;
            p2_meta_reg <= p1_meta_reg;
        end
    end

    baf_cross u_cross (
        .clk (clk),
        .en  (en),
        .ax  (p0_ax_reg),
        .ay  (p0_ay_reg),
        .az  (cross_az)
    );

    // ---------------- output ----------------
    always_comb
    begin
        az_sel = '0;
        case (p2_meta_reg.kind)
            baf_pkg::CASE_ON_X:
            begin
                az_sel[2] = baf_pkg::ONE_Q14;
            end
            baf_pkg::CASE_ON_Y, baf_pkg::CASE_ON_Z:
            begin
                az_sel[0] = baf_pkg::ONE_Q14;
            end
            default:
            begin
                az_sel = cross_az;
            end
        endcase

        out_next = '0;
        out_next.too_short = p2_meta_reg.too_short;
        if (!p2_meta_reg.too_short)
        begin
            out_next.axis_x_x = p2_ax_reg[0];
            out_next.axis_x_y = p2_ax_reg[1];
            out_next.axis_x_z = p2_ax_reg[2];
            out_next.axis_y_x = p2_ay_reg[0];
            out_next.axis_y_y = p2_ay_reg[1];
            out_next.axis_y_z = p2_ay_reg[2];
            out_next.axis_z_x = az_sel[0];
            out_next.axis_z_y = az_sel[1];
            out_next.axis_z_z = az_sel[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // ---------------- assertions ----------------
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.too_short |->
            out_data.axis_x_x == '0 && out_data.axis_x_y == '0 && out_data.axis_x_z == '0
            && out_data.axis_z_x == '0 && out_data.axis_z_y == '0
            && out_data.axis_z_z == '0)
        else $error("too_short result carries nonzero axes");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.axis_x_x <= baf_pkg::ONE_Q14
                   && out_data.axis_x_x >= -baf_pkg::ONE_Q14)
        else $error("axis component out of Q2.14 unit range");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> s1_vld_reg)
        else $error("accepted request not captured");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_stall |=> $stable(p0_vld_reg) && $stable(dl_vld_reg))
        else $error("pipeline moved while output held");

endmodule
